@@ design/ljpf_pkg.sv @@
// shared types and constants of the lennard-jones pair force block
package ljpf_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_SQ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS24     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ = 2'd2;

  localparam logic [31:0] SIGMA_SQ_RST  = 32'd65536;
  localparam logic [31:0] EPS24_RST     = 32'd1572864;
  localparam logic [31:0] CUTOFF_SQ_RST = 32'd409600;

  localparam logic [63:0] CAP63    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TERM_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN  = 48'h8000_0000_0000;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [127:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage

@@ design/ljpf_mul.sv @@
// 64 by 64 unsigned multiplier built from one 32 by 32 multiplier that forms the partial products one by one
module ljpf_mul import ljpf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic         busy_q, busy_d;
  logic [3:0]   pend_q, pend_d;
  logic         ppvld_q, ppvld_d;
  logic [1:0]   ppidx_q, ppidx_d;
  logic [63:0]  pp_q, pp_d;
  logic [63:0]  a_q, a_d, b_q, b_d;
  logic [127:0] acc_q, acc_d;
  logic [1:0]   sel;
  logic [31:0]  a_sel, b_sel;
  logic [6:0]   sh;
  logic         done;
  logic         a_hi, b_hi;

  assign a_hi = |req_i.a[63:32];
  assign b_hi = |req_i.b[63:32];

  // lowest pending partial product goes first
  always_comb begin
    if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else if (pend_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign a_sel = sel[1] ? a_q[63:32] : a_q[31:0];
  assign b_sel = sel[0] ? b_q[63:32] : b_q[31:0];

  always_comb begin
    case (ppidx_q)
      2'd0:    sh = 7'd0;
      2'd3:    sh = 7'd64;
      default: sh = 7'd32;
    endcase
  end

  assign done = busy_q && (pend_q == 4'd0) && !ppvld_q;

  always_comb begin
    busy_d  = busy_q;
    pend_d  = pend_q;
    ppvld_d = 1'b0;
    ppidx_d = ppidx_q;
    pp_d    = pp_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      a_d    = req_i.a;
      b_d    = req_i.b;
      acc_d  = '0;
      pend_d = {a_hi && b_hi, a_hi, b_hi, 1'b1};
    end else begin
      if (busy_q && (pend_q != 4'd0)) begin
        pend_d  = pend_q & ~(4'd1 << sel);
        pp_d    = 64'(a_sel) * 64'(b_sel);
        ppidx_d = sel;
        ppvld_d = 1'b1;
      end
      if (ppvld_q) begin
        acc_d = acc_q + (128'(pp_q) << sh);
      end
      if (done) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pend_q  <= 4'd0;
      ppvld_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      pend_q  <= pend_d;
      ppvld_q <= ppvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ppidx_q <= ppidx_d;
    pp_q    <= pp_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done;
  assign rsp_o.prod = acc_q;

endmodule

@@ design/ljpf_div.sv @@
// radix-2 restoring divider forming 2^(2*frac_bits) over the squared distance
module ljpf_div import ljpf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned QW = 2 * FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(QW);

  logic          busy_q, busy_d;
  logic          fin_q, fin_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   dvs_q, dvs_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [32:0]   rem_sh, rem_sub;
  logic          ge;

  // the dividend is a single one at its top bit
  assign rem_sh  = {rem_q, cnt_q == CW'(QW - 1)};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    fin_d  = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(QW - 1);
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sub[31:0] : rem_sh[31:0];
      quot_d = {quot_q[QW-2:0], ge};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign rsp_o.busy = busy_q || fin_q;
  assign rsp_o.done = fin_q;
  assign rsp_o.quot = 64'(quot_q);

endmodule

@@ design/lennard_jones_pair_force.sv @@
// top level of the lennard-jones pair force accumulator with cutoff
//
// usage: one neighbour pair per input beat on s_axis; tdata carries the
// current and neighbour positions, tuser marks a self-pair and tlast the
// last neighbour of the atom. the force sums grow pair by pair; on a tlast
// beat the three sums and the saturation flag leave as one m_axis beat and
// the sums clear. the cfg channel writes sigma squared, 24 epsilon and the
// squared cutoff; it is always ready, and the user must write it only while
// the block is idle, which the block itself does not enforce. an input beat
// is taken only in the idle state. a self-pair goes straight to the end, a
// pair at or beyond the cutoff or at zero distance stops after the squares,
// and an interacting pair runs three squares, a divider of 2*FRAC_BITS+1
// steps and nine scaled products, all on one 32 by 32 multiplier that needs
// 1 to 4 passes per product. the result sits in an output register; while
// the receiver stalls the next pairs are still taken, and a later tlast pair
// waits until that register is free. reset clears the sums, the flag and the
// output valid, and loads the registers with their default values.
module lennard_jones_pair_force import ljpf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // current_x, current_y, current_z, other_x, other_y, other_z
  input  logic [191:0]         s_axis_tdata,
  // same_atom
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // force_x, force_y, force_z
  output logic [143:0]         m_axis_tdata,
  // saturated
  output logic                 m_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned QW  = 2 * FRAC_BITS + 1;
  localparam int unsigned R2W = 66 - FRAC_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_CHK  = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_MS   = 4'd4;
  localparam logic [3:0] ST_MSS  = 4'd5;
  localparam logic [3:0] ST_MR6  = 4'd6;
  localparam logic [3:0] ST_MSQ  = 4'd7;
  localparam logic [3:0] ST_BRK  = 4'd8;
  localparam logic [3:0] ST_ME   = 4'd9;
  localparam logic [3:0] ST_MI   = 4'd10;
  localparam logic [3:0] ST_TRM  = 4'd11;
  localparam logic [3:0] ST_ACC  = 4'd12;
  localparam logic [3:0] ST_FIN  = 4'd13;

  logic [3:0]     state_q, state_d;
  logic           issued_q, issued_d;
  logic [1:0]     axis_q, axis_d;
  logic           ovf_q, ovf_d;
  logic [47:0]    sum_q [3];
  logic [47:0]    sum_d [3];
  logic           m_valid_q, m_valid_d;
  logic [31:0]    sigma_q, eps_q, cut_q;

  logic [31:0]    mag_q [3];
  logic [31:0]    mag_d [3];
  logic [2:0]     dneg_q, dneg_d;
  logic           last_q, last_d;
  logic [R2W-1:0] r2_q, r2_d;
  logic [QW-1:0]  rr2_q, rr2_d;
  logic [63:0]    s_q, s_d, w_q, w_d, r6_q, r6_d;
  logic           bneg_q, bneg_d;
  logic [46:0]    term_q, term_d;
  logic           tneg_q, tneg_d;
  logic [143:0]   out_q, out_d;
  logic           osat_q, osat_d;

  logic [32:0]    in_diff [3];
  logic [31:0]    in_mag [3];
  logic [2:0]     in_neg;

  mul_req_t       mul_req;
  mul_rsp_t       mul_rsp;
  div_req_t       div_req;
  div_rsp_t       div_rsp;
  logic           mul_op;
  logic           mq_sat, dbl_sat, term_sat;
  logic [63:0]    mq_val, dbl_val;
  logic [48:0]    term_u;
  logic signed [48:0] term_ext, acc_w;
  logic           acc_sat;
  logic [47:0]    acc_res;
  logic           emit;

  ljpf_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  ljpf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = osat_q;

  // position differences and their magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_diff[i] = {s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]}
                 - {s_axis_tdata[32*(i+3)+31], s_axis_tdata[32*(i+3) +: 32]};
      in_neg[i]  = in_diff[i][32];
      in_mag[i]  = in_diff[i][32] ? 32'(-in_diff[i]) : in_diff[i][31:0];
    end
  end

  // scaled product with saturation
  assign mq_sat  = |mul_rsp.prod[127:63+FRAC_BITS];
  assign mq_val  = mq_sat ? CAP63 : mul_rsp.prod[63+FRAC_BITS:FRAC_BITS];
  assign dbl_sat = mq_val > (CAP63 >> 1);
  assign dbl_val = dbl_sat ? CAP63 : {mq_val[62:0], 1'b0};
  assign term_sat = mq_val > TERM_MAX;

  // signed accumulate with saturation
  assign term_u   = {2'b00, term_q};
  assign term_ext = tneg_q ? -$signed(term_u) : $signed(term_u);
  assign acc_w    = $signed({sum_q[axis_q][47], sum_q[axis_q]}) + term_ext;
  assign acc_sat  = acc_w[48] ^ acc_w[47];
  assign acc_res  = acc_sat ? (acc_w[48] ? SUM_MIN : SUM_MAX) : acc_w[47:0];

  assign mul_op = state_q inside {ST_SQ, ST_MS, ST_MSS, ST_MR6, ST_MSQ, ST_ME, ST_MI, ST_TRM};

  always_comb begin
    mul_req.start = mul_op && !issued_q;
    case (state_q)
      ST_SQ: begin
        mul_req.a = 64'(mag_q[axis_q]);
        mul_req.b = 64'(mag_q[axis_q]);
      end
      ST_MS: begin
        mul_req.a = 64'(sigma_q);
        mul_req.b = 64'(rr2_q);
      end
      ST_MSS: begin
        mul_req.a = s_q;
        mul_req.b = s_q;
      end
      ST_MR6: begin
        mul_req.a = w_q;
        mul_req.b = s_q;
      end
      ST_MSQ: begin
        mul_req.a = r6_q;
        mul_req.b = r6_q;
      end
      ST_ME: begin
        mul_req.a = 64'(eps_q);
        mul_req.b = 64'(rr2_q);
      end
      ST_MI: begin
        mul_req.a = w_q;
        mul_req.b = s_q;
      end
      ST_TRM: begin
        mul_req.a = w_q;
        mul_req.b = 64'(mag_q[axis_q]);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  assign div_req.start   = (state_q == ST_DIV) && !issued_q;
  assign div_req.divisor = r2_q[31:0];

  always_comb begin
    state_d   = state_q;
    issued_d  = issued_q;
    axis_d    = axis_q;
    ovf_d     = ovf_q;
    sum_d     = sum_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    mag_d     = mag_q;
    dneg_d    = dneg_q;
    last_d    = last_q;
    r2_d      = r2_q;
    rr2_d     = rr2_q;
    s_d       = s_q;
    w_d       = w_q;
    r6_d      = r6_q;
    bneg_d    = bneg_q;
    term_d    = term_q;
    tneg_d    = tneg_q;
    out_d     = out_q;
    osat_d    = osat_q;
    emit      = 1'b0;

    if (mul_req.start || div_req.start) begin
      issued_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mag_d   = in_mag;
          dneg_d  = in_neg;
          last_d  = s_axis_tlast;
          r2_d    = '0;
          axis_d  = 2'd0;
          state_d = s_axis_tuser ? ST_FIN : ST_SQ;
        end
      end
      ST_SQ: begin
        if (mul_rsp.done) begin
          issued_d = 1'b0;
          r2_d     = r2_q + R2W'(mul_rsp.prod[63:FRAC_BITS]);
          if (axis_q == 2'd2) begin
            axis_d  = 2'd0;
            state_d = ST_CHK;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end
      end
      ST_CHK: begin
        if ((r2_q != '0) && (r2_q < R2W'(cut_q))) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          issued_d = 1'b0;
          rr2_d    = div_rsp.quot[QW-1:0];
          state_d  = ST_MS;
        end
      end
      ST_MS: begin
        if (mul_rsp.done) begin
          issued_d = 1'b0;
          s_d      = mq_val;
          ovf_d    = ovf_q || mq_sat;
          state_d  = ST_MSS;
        end
      end
      ST_MSS: begin
        if (mul_rsp.done) begin
          issued_d = 1'b0;
          w_d      = mq_val;
          ovf_d    = ovf_q || mq_sat;
          state_d  = ST_MR6;
        end
      end
      ST_MR6: begin
        if (mul_rsp.done) begin
          issued_d = 1'b0;
          r6_d     = mq_val;
          ovf_d    = ovf_q || mq_sat;
          state_d  = ST_MSQ;
        end
      end
      ST_MSQ: begin
        if (mul_rsp.done) begin
          issued_d = 1'b0;
          w_d      = dbl_val;
          ovf_d    = ovf_q || mq_sat || dbl_sat;
          state_d  = ST_BRK;
        end
      end
      ST_BRK: begin
        // bracket kept as magnitude and sign
        if (w_q >= r6_q) begin
          s_d    = w_q - r6_q;
          bneg_d = 1'b0;
        end else begin
          s_d    = r6_q - w_q;
          bneg_d = 1'b1;
        end
        state_d = ST_ME;
      end
      ST_ME: begin
        if (mul_rsp.done) begin
          issued_d = 1'b0;
          w_d      = mq_val;
          ovf_d    = ovf_q || mq_sat;
          state_d  = ST_MI;
        end
      end
      ST_MI: begin
        if (mul_rsp.done) begin
          issued_d = 1'b0;
          w_d      = mq_val;
          ovf_d    = ovf_q || mq_sat;
          state_d  = ST_TRM;
        end
      end
      ST_TRM: begin
        if (mul_rsp.done) begin
          issued_d = 1'b0;
          term_d   = term_sat ? TERM_MAX[46:0] : mq_val[46:0];
          tneg_d   = bneg_q ^ dneg_q[axis_q];
          ovf_d    = ovf_q || mq_sat || term_sat;
          state_d  = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_d[axis_q] = acc_res;
        ovf_d         = ovf_q || acc_sat;
        if (axis_q == 2'd2) begin
          axis_d  = 2'd0;
          state_d = ST_FIN;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_TRM;
        end
      end
      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!m_valid_q || m_axis_tready) begin
          emit      = 1'b1;
          m_valid_d = 1'b1;
          out_d     = {sum_q[2], sum_q[1], sum_q[0]};
          osat_d    = ovf_q;
          sum_d[0]  = '0;
          sum_d[1]  = '0;
          sum_d[2]  = '0;
          ovf_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issued_q  <= 1'b0;
      axis_q    <= 2'd0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      issued_q  <= issued_d;
      axis_q    <= axis_d;
      ovf_q     <= ovf_d;
      m_valid_q <= m_valid_d;
      sum_q     <= sum_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= SIGMA_SQ_RST;
      eps_q   <= EPS24_RST;
      cut_q   <= CUTOFF_SQ_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SIGMA_SQ:  sigma_q <= cfg_data_i;
        CFG_EPS24:     eps_q   <= cfg_data_i;
        CFG_CUTOFF_SQ: cut_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    dneg_q <= dneg_d;
    last_q <= last_d;
    r2_q   <= r2_d;
    rr2_q  <= rr2_d;
    s_q    <= s_d;
    w_q    <= w_d;
    r6_q   <= r6_d;
    bneg_q <= bneg_d;
    term_q <= term_d;
    tneg_q <= tneg_d;
    out_q  <= out_d;
    osat_q <= osat_d;
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy && !mul_rsp.busy)
    else $error("divider started while a unit is busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !mul_rsp.busy && !div_rsp.busy)
    else $error("input taken while the shared units are busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_valid_q && !ovf_q && (sum_q[0] == '0) && (sum_q[1] == '0)
             && (sum_q[2] == '0))
    else $error("sums not cleared after result beat");
`endif

endmodule
